[hdl/podf_pkg.sv]
`timescale 1ns / 1ps
// Package for the per-origin duplicate filter.
// Holds opcode codes, signature width and parameter defaults; no dependencies.
package podf_pkg;

	localparam int DEFAULT_MAX_ORIGINS   = 64;
	localparam int DEFAULT_HISTORY_DEPTH = 8;

	localparam int SIG_W = 25;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef logic [SIG_W-1:0] sig_t;

endpackage

[hdl/per_origin_duplicate_filter_core.sv]
`timescale 1ns / 1ps
// Top level of the per-origin duplicate filter: sequencer, history memories.
// Depends on podf_pkg.
//
// Each origin keeps its last HISTORY_DEPTH packet signatures {kind, sequence, hop}.
// A transaction is accepted when start is high and busy is low; its result shows
// on done/is_duplicate for exactly one cycle and cannot be stalled. A check walks
// the origin's row through the single compare unit, one stored signature per
// cycle from a signature memory with one read and one write port: busy stays
// high through the row read, the compares and any write-back, and done rises as
// busy falls. A miss writes the signature back in S_WR, the last busy state.
// A check for an origin at or beyond MAX_ORIGINS gives is_duplicate = 0 in the
// next cycle without going busy. A clear transaction sweeps the per-row pointer
// memory, one row a cycle, staying busy until the last row is cleared. After
// reset the same sweep runs with busy high and no result.
module per_origin_duplicate_filter_core
	import podf_pkg::*;
#(
	parameter int MAX_ORIGINS   = DEFAULT_MAX_ORIGINS,
	parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic        packet_kind,
	input  logic [5:0]  origin_node,
	input  logic [15:0] sequence_number,
	input  logic [7:0]  hop_number,
	output logic        done,
	output logic        is_duplicate
);

	localparam int ORG_W     = $clog2(MAX_ORIGINS);
	localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int ADDR_W    = ORG_W + SLOT_W;
	localparam int SIG_DEPTH = MAX_ORIGINS * (2 ** SLOT_W);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [ORG_W-1:0]  LAST_ROW  = ORG_W'(MAX_ORIGINS - 1);

	typedef struct packed {
		logic              full;
		logic [SLOT_W-1:0] ptr;
	} row_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CMP,
		S_WR,
		S_CLEAR
	} state_t;

	state_t            state_q;
	logic [ORG_W-1:0]  clr_idx_q;
	logic              clr_item_q;
	logic [ORG_W-1:0]  org_q;
	sig_t              sig_q;
	logic [SLOT_W-1:0] slot_q;
	row_t              row_q;
	logic              done_q;
	logic              dup_q;

	sig_t              sig_mem [SIG_DEPTH];
	row_t              row_mem [MAX_ORIGINS];
	sig_t              sig_rd_q;
	row_t              row_rd_q;

	logic              accept;
	logic              in_range;
	logic [SLOT_W-1:0] slot_nxt;
	logic              cmp_last;
	logic [ORG_W-1:0]  row_rd_addr;
	logic              row_we;
	logic [ORG_W-1:0]  row_wr_addr;
	row_t              row_wr_data;
	row_t              row_upd;
	logic [ADDR_W-1:0] sig_rd_addr;
	logic [ADDR_W-1:0] sig_wr_addr;
	logic              sig_we;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign is_duplicate = dup_q;

	assign accept   = start && !busy;
	assign in_range = (32'(origin_node) < 32'(MAX_ORIGINS));
	assign slot_nxt = slot_q + SLOT_W'(1);
	assign cmp_last = (slot_q == LAST_SLOT) || (!row_q.full && (slot_nxt == row_q.ptr));

	always_comb begin
		row_upd.full = row_q.full || (row_q.ptr == LAST_SLOT);
		row_upd.ptr  = (row_q.ptr == LAST_SLOT) ? '0 : row_q.ptr + SLOT_W'(1);
	end

	assign row_rd_addr = ORG_W'(origin_node);
	assign row_we      = (state_q == S_CLEAR) || (state_q == S_WR);
	assign row_wr_addr = (state_q == S_CLEAR) ? clr_idx_q : org_q;
	assign row_wr_data = (state_q == S_CLEAR) ? '0 : row_upd;

	assign sig_rd_addr = {org_q, (state_q == S_ROW) ? {SLOT_W{1'b0}} : slot_nxt};
	assign sig_wr_addr = {org_q, row_q.ptr};
	assign sig_we      = (state_q == S_WR);

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wr_addr] <= row_wr_data;
		end
		row_rd_q <= row_mem[row_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[sig_wr_addr] <= sig_q;
		end
		sig_rd_q <= sig_mem[sig_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			clr_item_q <= 1'b0;
			done_q     <= 1'b0;
			dup_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			dup_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						org_q <= ORG_W'(origin_node);
						sig_q <= {packet_kind, sequence_number, hop_number};
						if (opcode == OP_CLEAR) begin
							clr_idx_q  <= '0;
							clr_item_q <= 1'b1;
							state_q    <= S_CLEAR;
						end else if (in_range) begin
							state_q <= S_ROW;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_ROW: begin
					row_q  <= row_rd_q;
					slot_q <= '0;
					if (!row_rd_q.full && (row_rd_q.ptr == '0)) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sig_rd_q == sig_q) begin
						done_q  <= 1'b1;
						dup_q   <= 1'b1;
						state_q <= S_IDLE;
					end else if (cmp_last) begin
						state_q <= S_WR;
					end else begin
						slot_q <= slot_nxt;
					end
				end
				S_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + ORG_W'(1);
					if (clr_idx_q == LAST_ROW) begin
						done_q     <= clr_item_q;
						clr_item_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/podf_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for per_origin_duplicate_filter_core, bound to the top level.
// Depends on podf_pkg.
module podf_checker
	import podf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        opcode,
	input logic        done,
	input logic        is_duplicate
);

	// a clear transaction sweeps all rows before answering
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_CLEAR) |=> busy && !done)
		else $error("clear transaction did not start the sweep");

	// a result needs a transaction in flight or just taken
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without transaction");

	// one strobe per transaction
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && !(start && !busy) |=> !done)
		else $error("repeated result strobe");

	// a clear never reports a duplicate
	a_clear_nodup: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_CLEAR) |=> !is_duplicate)
		else $error("duplicate flag during clear");

endmodule

bind per_origin_duplicate_filter_core podf_checker u_podf_checker (.*);

[tb/podf_checker.sv]
`timescale 1ns / 1ps
// Result checker for the per-origin duplicate filter: watches transactions, predicts
// the duplicate flag from its own copy of the history rows and compares each result.
// Depends on podf_pkg.
module podf_result_checker
	import podf_pkg::*;
#(
	parameter int MAX_ORIGINS   = DEFAULT_MAX_ORIGINS,
	parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        opcode,
	input  logic        packet_kind,
	input  logic [5:0]  origin_node,
	input  logic [15:0] sequence_number,
	input  logic [7:0]  hop_number,
	input  logic        done,
	input  logic        is_duplicate,
	output int          fail_count = 0,
	output int          outstanding = 0,
	output int          results_seen = 0,
	output int          duplicates_seen = 0
);

	sig_t        history_sig [MAX_ORIGINS][HISTORY_DEPTH];
	bit          history_vld [MAX_ORIGINS][HISTORY_DEPTH];
	int unsigned write_slot  [MAX_ORIGINS];
	bit          pending_dup_flags [$];

	function automatic bit predict_is_duplicate(input logic op, input logic kind,
			input logic [5:0] org, input logic [15:0] seq, input logic [7:0] hop);
		sig_t        sig;
		int unsigned slot;
		if (op == OP_CLEAR) begin
			foreach (history_vld[r, s])
				history_vld[r][s] = 1'b0;
			foreach (write_slot[r])
				write_slot[r] = 0;
			return 1'b0;
		end
		if (org >= MAX_ORIGINS)
			return 1'b0;
		sig = {kind, seq, hop};
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (history_vld[org][i] && history_sig[org][i] == sig)
				return 1'b1;
		end
		slot = write_slot[org];
		if (slot >= HISTORY_DEPTH)
			slot = 0;
		history_sig[org][slot] = sig;
		history_vld[org][slot] = 1'b1;
		write_slot[org] = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		bit want_dup;
		if (arst_n) begin
			// result of an older transaction is retired before a new one is queued
			if (done) begin
				results_seen++;
				if (is_duplicate === 1'b1)
					duplicates_seen++;
				if (pending_dup_flags.size() == 0) begin
					fail_count++;
					$display("%0t ERROR: unexpected result, expected none, actual is_duplicate=%0b",
						$time, is_duplicate);
				end else begin
					want_dup = pending_dup_flags.pop_front();
					if (is_duplicate !== want_dup) begin
						fail_count++;
						$display("%0t ERROR: is_duplicate expected %0b, actual %0b",
							$time, want_dup, is_duplicate);
					end
				end
			end
			if (start && !busy)
				pending_dup_flags.push_back(predict_is_duplicate(opcode, packet_kind,
					origin_node, sequence_number, hop_number));
			outstanding <= pending_dup_flags.size();
		end
	end

endmodule

[tb/per_origin_duplicate_filter_core_test.sv]
`timescale 1ns / 1ps
// Testbench top for per_origin_duplicate_filter_core: directed and random packet traffic.
// Depends on podf_pkg, the filter core and podf_result_checker.
module per_origin_duplicate_filter_core_test;
	import podf_pkg::*;

	typedef struct {
		logic        kind;
		logic [5:0]  org;
		logic [15:0] seq;
		logic [7:0]  hop;
	} packet_sig_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = OP_CHECK;
	logic        packet_kind = 1'b0;
	logic [5:0]  origin_node = '0;
	logic [15:0] sequence_number = '0;
	logic [7:0]  hop_number = '0;
	wire         busy;
	wire         done;
	wire         is_duplicate;

	int fail_count;
	int outstanding;
	int results_seen;
	int duplicates_seen;
	int items_sent = 0;
	int clears_sent = 0;

	packet_sig_t recent_packets [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	per_origin_duplicate_filter_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .packet_kind(packet_kind), .origin_node(origin_node),
		.sequence_number(sequence_number), .hop_number(hop_number),
		.done(done), .is_duplicate(is_duplicate)
	);

	podf_result_checker result_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .packet_kind(packet_kind), .origin_node(origin_node),
		.sequence_number(sequence_number), .hop_number(hop_number),
		.done(done), .is_duplicate(is_duplicate),
		.fail_count(fail_count), .outstanding(outstanding),
		.results_seen(results_seen), .duplicates_seen(duplicates_seen)
	);

	// leaves start high; the caller lowers it when a gap follows
	task automatic issue(input logic op, input logic kind, input logic [5:0] org,
			input logic [15:0] seq, input logic [7:0] hop);
		start           <= 1'b1;
		opcode          <= op;
		packet_kind     <= kind;
		origin_node     <= org;
		sequence_number <= seq;
		hop_number      <= hop;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (op == OP_CLEAR) begin
			clears_sent++;
		end else begin
			recent_packets.push_back('{kind, org, seq, hop});
			if (recent_packets.size() > 48)
				void'(recent_packets.pop_front());
		end
	endtask

	task automatic random_transaction();
		int          pick;
		packet_sig_t p;
		pick = $urandom_range(99);
		if (pick < 3) begin
			issue(OP_CLEAR, 1'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
			return;
		end
		if (pick < 55 && recent_packets.size() != 0) begin
			p = recent_packets[$urandom_range(recent_packets.size() - 1)];
			if (pick >= 43) begin
				// near miss: one field of a known signature differs
				case ($urandom_range(2))
					0: p.kind = ~p.kind;
					1: p.seq[$urandom_range(15)] ^= 1'b1;
					default: p.hop[$urandom_range(7)] ^= 1'b1;
				endcase
			end
		end else if (pick < 80) begin
			case ($urandom_range(4))
				0: p.org = 6'd0;
				1: p.org = 6'd1;
				2: p.org = 6'd2;
				3: p.org = 6'd63;
				default: p.org = 6'($urandom_range(3));
			endcase
			p.kind = 1'($urandom);
			p.seq  = 16'($urandom);
			p.hop  = 8'($urandom);
		end else begin
			p.kind = 1'($urandom);
			p.org  = 6'($urandom);
			p.seq  = 16'($urandom);
			p.hop  = 8'($urandom);
		end
		issue(OP_CHECK, p.kind, p.org, p.seq, p.hop);
	endtask

	initial begin
		int burst_len;
		int gap;
		int guard;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_CHECK, 1'b0, 6'd0,  16'h0000, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0000, 8'h00);
		issue(OP_CHECK, 1'b1, 6'd0,  16'h0000, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0001, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0000, 8'h01);
		issue(OP_CHECK, 1'b1, 6'd63, 16'hFFFF, 8'hFF);
		issue(OP_CHECK, 1'b1, 6'd63, 16'hFFFF, 8'hFF);
		issue(OP_CHECK, 1'b1, 6'd62, 16'hFFFF, 8'hFF);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h8000, 8'h80);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0002, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0003, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0004, 8'h00);
		// row 0 full: next miss evicts the oldest entry
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0005, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0000, 8'h00);
		issue(OP_CHECK, 1'b1, 6'd0,  16'h0000, 8'h00);
		issue(OP_CHECK, 1'b0, 6'd0,  16'h0005, 8'h00);
		issue(OP_CLEAR, 1'b1, 6'd63, 16'hFFFF, 8'hFF);
		issue(OP_CHECK, 1'b1, 6'd63, 16'hFFFF, 8'hFF);
		issue(OP_CHECK, 1'b1, 6'd63, 16'hFFFF, 8'hFF);

		while (items_sent < 520) begin
			burst_len = $urandom_range(1, 12);
			repeat (burst_len)
				random_transaction();
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		guard = 0;
		while (outstanding != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DEFAULT_MAX_ORIGINS + 16) @(posedge clk);

		$display("Run covered %0d transactions (%0d history clears).", items_sent, clears_sent);
		$display("%0d results compared, %0d of them reported as duplicates.",
			results_seen, duplicates_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("per_origin_duplicate_filter_core: match");
		else
			$display("per_origin_duplicate_filter_core: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("per_origin_duplicate_filter_core: mismatch");
		$finish;
	end

endmodule

[files.f]
hdl/podf_pkg.sv
hdl/per_origin_duplicate_filter_core.sv
hdl/podf_checker.sv
tb/podf_checker.sv
tb/per_origin_duplicate_filter_core_test.sv
